>>> design/assert_macros.svh
// Assertion macros shared by the RTL files of the button press classifier.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> design/bpdc_pkg.sv
// Package for the button press duration classifier: widths, event codes,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package bpdc_pkg;

    localparam int TimeW  = 32;
    localparam int EventW = 2;
    localparam int CfgIdxW = 2;

    typedef logic [TimeW-1:0]   t_time;
    typedef logic [EventW-1:0]  t_event;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // Event codes reported per sample.
    localparam t_event EV_NONE    = 2'd0;
    localparam t_event EV_SHORT   = 2'd1;
    localparam t_event EV_MESSAGE = 2'd2;
    localparam t_event EV_CHANGE  = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_FILTER  = 2'd0;
    localparam t_cfg_idx CFG_MESSAGE = 2'd1;
    localparam t_cfg_idx CFG_CHANGE  = 2'd2;

    // Register reset values in milliseconds.
    localparam t_time FILTER_RESET  = 32'd50;
    localparam t_time MESSAGE_RESET = 32'd1000;
    localparam t_time CHANGE_RESET  = 32'd3000;

endpackage

`default_nettype wire

>>> design/button_press_duration_classifier_core.sv
// Top level of the button press duration classifier: input register, hold
// time classification and result register. Depends on bpdc_pkg and
// assert_macros.svh.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | sink      | i_in_valid / o_in_ready | i_key_level, i_time_now
//   out      | source    | o_out_valid / i_out_ready | o_event_code
//   cfg      | sink      | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// One sample per cycle while the output is not stalled.
// The wrapped hold-time subtract and three 32-bit compares sit between the input
// register and the result register, and the press state updates in that step.
// Reset is synchronous and active low; it clears the valid flags, the press
// state and restores the register defaults.
// A stalled output holds the result; one more sample can still be taken into
// the input register before o_in_ready drops.
`default_nettype none

module button_press_duration_classifier_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input samples.
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_key_level,
    input  wire bpdc_pkg::t_time        i_time_now,
    // Results.
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output bpdc_pkg::t_event            o_event_code,
    // Configuration writes.
    input  wire logic                   i_cfg_we,
    input  wire bpdc_pkg::t_cfg_idx     i_cfg_index,
    input  wire bpdc_pkg::t_time        i_cfg_data
);

`include "assert_macros.svh"

    // Configuration registers.
    bpdc_pkg::t_time r_filter_time;
    bpdc_pkg::t_time r_message_time;
    bpdc_pkg::t_time r_change_time;

    // Input register.
    logic            r_in_valid;
    logic            r_in_key_level;
    bpdc_pkg::t_time r_in_time;

    // Press state.
    bpdc_pkg::t_time r_press_start;
    logic            r_press_armed;
    logic            r_press_qualified;
    logic            r_change_fired;

    // Result register.
    logic             r_out_valid;
    bpdc_pkg::t_event r_event;

    // Next values.
    bpdc_pkg::t_time  n_press_start;
    logic             n_press_armed;
    logic             n_press_qualified;
    logic             n_change_fired;
    bpdc_pkg::t_event n_event;

    bpdc_pkg::t_time held;
    logic            advance;
    logic            process;

    assign advance    = !r_out_valid || i_out_ready;
    assign process    = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

    // Wrapping subtraction gives the hold time modulo 2^32.
    assign held = r_in_time - r_press_start;

    always_comb begin
        n_press_start     = r_press_start;
        n_press_armed     = r_press_armed;
        n_press_qualified = r_press_qualified;
        n_change_fired    = r_change_fired;
        n_event           = bpdc_pkg::EV_NONE;
        if (!r_in_key_level) begin
            // After the change event, pressed samples are ignored until release.
            if (!r_change_fired) begin
                if (!r_press_armed) begin
                    n_press_start = r_in_time;
                    n_press_armed = 1'b1;
                end else if (held < r_filter_time) begin
                    n_event = bpdc_pkg::EV_NONE;
                end else if (held < r_message_time) begin
                    n_press_qualified = 1'b1;
                end else if (held < r_change_time) begin
                    n_event = bpdc_pkg::EV_MESSAGE;
                end else begin
                    n_change_fired = 1'b1;
                    n_press_start  = r_in_time;
                    n_event        = bpdc_pkg::EV_CHANGE;
                end
            end
        end else begin
            if (!r_change_fired && r_press_qualified) begin
                n_event = bpdc_pkg::EV_SHORT;
            end
            n_press_armed     = 1'b0;
            n_press_qualified = 1'b0;
            n_change_fired    = 1'b0;
            n_press_start     = r_in_time;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_time  <= bpdc_pkg::FILTER_RESET;
            r_message_time <= bpdc_pkg::MESSAGE_RESET;
            r_change_time  <= bpdc_pkg::CHANGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpdc_pkg::CFG_FILTER:  r_filter_time  <= i_cfg_data;
                bpdc_pkg::CFG_MESSAGE: r_message_time <= i_cfg_data;
                bpdc_pkg::CFG_CHANGE:  r_change_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_key_level <= i_key_level;
            r_in_time      <= i_time_now;
        end
    end

    // Press state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_start     <= '0;
            r_press_armed     <= 1'b0;
            r_press_qualified <= 1'b0;
            r_change_fired    <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (process) begin
                r_press_start     <= n_press_start;
                r_press_armed     <= n_press_armed;
                r_press_qualified <= n_press_qualified;
                r_change_fired    <= n_change_fired;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_event <= n_event;
        end
    end

    // A qualified press or a fired change always belongs to an armed press.
    `ASSERT_NEVER(a_qual_unarmed, i_clk, i_rst_n, r_press_qualified && !r_press_armed)
    `ASSERT_NEVER(a_change_unarmed, i_clk, i_rst_n, r_change_fired && !r_press_armed)
    // A change event leaves the press locked until the next release.
    `ASSERT_CLK(a_change_locks, i_clk, i_rst_n,
        (process && n_event == bpdc_pkg::EV_CHANGE) |=> r_change_fired)
    // A waiting sample is not lost while the result side is stalled.
    `ASSERT_CLK(a_in_held, i_clk, i_rst_n, (r_in_valid && !advance) |=> r_in_valid)

endmodule

`default_nettype wire
